### hdl/ihex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers of the HEX record loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int unsigned RECORD_MAX    = 256;
  localparam int unsigned BUF_IDX_W     = $clog2(RECORD_MAX);
  localparam int unsigned OP_FIFO_DEPTH = 4;
  localparam int unsigned OP_PTR_W      = $clog2(OP_FIFO_DEPTH);

  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_OK     = 3'd1,
    ST_TRUNC  = 3'd2,
    ST_TYPE   = 3'd3,
    ST_IGNORE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_SEEK    = 4'd0,
    PH_LEN_HI  = 4'd1,
    PH_LEN_LO  = 4'd2,
    PH_AHI_HI  = 4'd3,
    PH_AHI_LO  = 4'd4,
    PH_ALO_HI  = 4'd5,
    PH_ALO_LO  = 4'd6,
    PH_TYPE_HI = 4'd7,
    PH_TYPE_LO = 4'd8,
    PH_DATA_HI = 4'd9,
    PH_DATA_LO = 4'd10,
    PH_CHK_HI  = 4'd11,
    PH_CHK_LO  = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_READ   = 2'd1,
    OP_COMMIT = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    B_CLEAR   = 3'd0,
    B_IDLE    = 3'd1,
    B_READ    = 3'd2,
    B_COPY_RD = 3'd3,
    B_COPY_WR = 3'd4
  } back_state_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  text_char;
    logic        is_last;
    logic [15:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_data;
  } out_item_t;

  // Work handed from the parser to the memory side.
  typedef struct packed {
    op_kind_e    kind;
    status_e     status;
    logic [15:0] addr;
    logic [7:0]  count;
  } op_t;

  typedef struct packed {
    logic                 en;
    logic [BUF_IDX_W-1:0] idx;
    logic [7:0]           data;
  } buf_wr_t;

  typedef struct packed {
    logic init_done;
    logic commit_done;
  } back_stat_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage

### hdl/intel_hex_record_loader_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_loader_top
// HEX text loader with a code memory read port. After reset the block
// clears code memory, one byte a cycle, and holds full high until the
// clear is done. Each request then gives exactly one result, in order.
// The parser takes one request a cycle while its work queue has room and
// no commit holds it back. A read is a registered memory read; the
// checksum character of a data record starts a commit that copies the
// record buffer into code memory, each byte read and then written.
// Requests behind a commit wait in the four-entry work queue until the
// copy ends, so long data records slow the stream. While a commit is still
// copying, the character that ends a data or checksum byte of the
// following record also waits.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_top #(
  parameter int unsigned CODE_DEPTH = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ihex_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ihex_pkg::out_item_t out_item_o
);
  import ihex_pkg::*;

  back_stat_t back_stat;
  logic       op_full;
  logic       op_push;
  op_t        op_in;
  logic       op_valid;
  logic       op_pop;
  op_t        op_head;
  buf_wr_t    buf_wr;

  ihex_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .back_stat_i(back_stat),
    .op_full_i  (op_full),
    .op_push_o  (op_push),
    .op_o       (op_in),
    .buf_wr_o   (buf_wr)
  );

  ihex_op_fifo u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .op_i   (op_in),
    .full_o (op_full),
    .valid_o(op_valid),
    .pop_i  (op_pop),
    .op_o   (op_head)
  );

  ihex_back #(
    .CODE_DEPTH(CODE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op_head),
    .op_pop_o   (op_pop),
    .buf_wr_i   (buf_wr),
    .back_stat_o(back_stat),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

### hdl/ihex_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_front
// Record parser: takes requests, decodes HEX text, fills the record buffer
// and hands status, read and commit work to the memory side.
// ----------------------------------------------------------------------------
module ihex_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  ihex_pkg::in_item_t  in_item_i,
  input  ihex_pkg::back_stat_t back_stat_i,
  input  logic                op_full_i,
  output logic                op_push_o,
  output ihex_pkg::op_t       op_o,
  output ihex_pkg::buf_wr_t   buf_wr_o
);
  import ihex_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  digit_high_q, digit_high_d;
  logic [7:0]  rec_len_q, rec_len_d;
  logic [15:0] rec_addr_q, rec_addr_d;
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic        decided_q, decided_d;
  logic        commit_busy_q, commit_busy_d;

  logic        accept;
  logic        last;
  logic [7:0]  pair_byte;
  logic        pair_end;
  logic        commit;
  status_e     status;

  // Hold off while a commit still copies out of the buffer and the next
  // character could overwrite it or start another commit.
  assign full_o = !back_stat_i.init_done || op_full_i ||
                  (commit_busy_q && (phase_q == PH_DATA_LO || phase_q == PH_CHK_LO));
  assign accept    = push_i && !full_o;
  assign op_push_o = accept;
  assign last      = in_item_i.is_last;
  assign pair_byte = {digit_high_q, hex_value(in_item_i.text_char)};

  always_comb begin
    phase_d      = phase_q;
    digit_high_d = digit_high_q;
    rec_len_d    = rec_len_q;
    rec_addr_d   = rec_addr_q;
    byte_cnt_d   = byte_cnt_q;
    decided_d    = decided_q;
    pair_end     = 1'b0;
    commit       = 1'b0;
    status       = ST_RUN;
    buf_wr_o     = '0;

    if (accept && !in_item_i.cmd) begin
      if (decided_q) begin
        if (last) begin
          decided_d = 1'b0;
          phase_d   = PH_SEEK;
        end
        status = ST_IGNORE;
      end else begin
        case (phase_q)
          PH_SEEK: begin
            if (in_item_i.text_char == CHAR_COLON) begin
              if (last) status = ST_TRUNC;
              else phase_d = PH_LEN_HI;
            end else begin
              status = last ? ST_OK : ST_RUN;
            end
          end
          PH_LEN_HI, PH_AHI_HI, PH_ALO_HI, PH_TYPE_HI, PH_DATA_HI, PH_CHK_HI: begin
            digit_high_d = hex_value(in_item_i.text_char);
            if (last) begin
              phase_d = PH_SEEK;
              status  = ST_TRUNC;
            end else begin
              phase_d = phase_e'(phase_q + 4'd1);
            end
          end
          PH_LEN_LO: begin
            rec_len_d = pair_byte;
            phase_d   = PH_AHI_HI;
            pair_end  = 1'b1;
          end
          PH_AHI_LO: begin
            rec_addr_d = {pair_byte, 8'h00};
            phase_d    = PH_ALO_HI;
            pair_end   = 1'b1;
          end
          PH_ALO_LO: begin
            rec_addr_d = {rec_addr_q[15:8], pair_byte};
            phase_d    = PH_TYPE_HI;
            pair_end   = 1'b1;
          end
          PH_TYPE_LO: begin
            if (pair_byte != 8'd0) begin
              phase_d = PH_SEEK;
              if (!last) decided_d = 1'b1;
              status = (pair_byte == 8'd1) ? ST_OK : ST_TYPE;
            end else begin
              byte_cnt_d = 8'd0;
              phase_d    = (rec_len_q != 8'd0) ? PH_DATA_HI : PH_CHK_HI;
              pair_end   = 1'b1;
            end
          end
          PH_DATA_LO: begin
            buf_wr_o.en   = 1'b1;
            buf_wr_o.idx  = byte_cnt_q;
            buf_wr_o.data = pair_byte;
            byte_cnt_d    = byte_cnt_q + 8'd1;
            phase_d = (({1'b0, byte_cnt_q} + 9'd1) >= {1'b0, rec_len_q}) ?
                      PH_CHK_HI : PH_DATA_HI;
            pair_end = 1'b1;
          end
          PH_CHK_LO: begin
            commit  = 1'b1;
            phase_d = PH_SEEK;
            status  = last ? ST_OK : ST_RUN;
          end
          default: begin
            phase_d = PH_SEEK;
            status  = last ? ST_OK : ST_RUN;
          end
        endcase
        if (pair_end && last) begin
          phase_d = PH_SEEK;
          status  = ST_TRUNC;
        end
      end
    end
  end

  always_comb begin
    op_o.kind   = OP_STATUS;
    op_o.status = status;
    op_o.addr   = rec_addr_q;
    op_o.count  = byte_cnt_q;
    if (in_item_i.cmd) begin
      op_o.kind   = OP_READ;
      op_o.status = ST_RUN;
      op_o.addr   = in_item_i.read_addr;
    end else if (commit) begin
      op_o.kind = OP_COMMIT;
    end
  end

  always_comb begin
    commit_busy_d = commit_busy_q;
    if (accept && !in_item_i.cmd && commit) commit_busy_d = 1'b1;
    else if (back_stat_i.commit_done) commit_busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SEEK;
      digit_high_q  <= 4'd0;
      rec_len_q     <= 8'd0;
      rec_addr_q    <= 16'd0;
      byte_cnt_q    <= 8'd0;
      decided_q     <= 1'b0;
      commit_busy_q <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      digit_high_q  <= digit_high_d;
      rec_len_q     <= rec_len_d;
      rec_addr_q    <= rec_addr_d;
      byte_cnt_q    <= byte_cnt_d;
      decided_q     <= decided_d;
      commit_busy_q <= commit_busy_d;
    end
  end

endmodule

### hdl/ihex_op_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_op_fifo
// Short queue of parser work between the parser and the memory side.
// ----------------------------------------------------------------------------
module ihex_op_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ihex_pkg::op_t op_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output ihex_pkg::op_t op_o
);
  import ihex_pkg::*;

  op_t                mem_q [OP_FIFO_DEPTH];
  logic [OP_PTR_W-1:0] wptr_q, rptr_q;
  logic [OP_PTR_W:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (OP_PTR_W+1)'(OP_FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/ihex_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_back
// Memory side: clears code memory after reset, copies committed records
// from the record buffer, serves reads and queues the results.
// ----------------------------------------------------------------------------
module ihex_back #(
  parameter int unsigned CODE_DEPTH = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  input  ihex_pkg::op_t        op_i,
  output logic                 op_pop_o,
  input  ihex_pkg::buf_wr_t    buf_wr_i,
  output ihex_pkg::back_stat_t back_stat_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ihex_pkg::out_item_t  out_item_o
);
  import ihex_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CODE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CODE_DEPTH - 1);
  localparam logic [16:0] DEPTH_LIM = 17'(CODE_DEPTH);

  logic [7:0] code_q [CODE_DEPTH];
  logic [7:0] rec_buf_q [RECORD_MAX];

  back_state_e         state_q, state_d;
  logic [ADDR_W-1:0]   clr_idx_q, clr_idx_d;
  logic [15:0]         op_addr_q, op_addr_d;
  logic [7:0]          op_cnt_q, op_cnt_d;
  status_e             op_status_q, op_status_d;
  logic                in_range_q, in_range_d;
  logic [BUF_IDX_W-1:0] copy_idx_q, copy_idx_d;

  logic                cs_we;
  logic [ADDR_W-1:0]   cs_waddr;
  logic [7:0]          cs_wdata;
  logic [ADDR_W-1:0]   cs_raddr;
  logic [7:0]          cs_rdata_q;
  logic [7:0]          buf_rdata_q;
  logic [16:0]         copy_addr;

  // Result queue, two entries.
  out_item_t out_mem_q [2];
  logic      out_wptr_q, out_rptr_q;
  logic [1:0] out_cnt_q;
  logic      out_push;
  out_item_t out_data;
  logic      out_pop;

  assign copy_addr  = {1'b0, op_addr_q} + 17'(copy_idx_q);
  assign cs_raddr   = op_i.addr[ADDR_W-1:0];
  assign empty_o    = (out_cnt_q == 2'd0);
  assign out_item_o = out_mem_q[out_rptr_q];
  assign out_pop    = pop_i && !empty_o;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    op_addr_d   = op_addr_q;
    op_cnt_d    = op_cnt_q;
    op_status_d = op_status_q;
    in_range_d  = in_range_q;
    copy_idx_d  = copy_idx_q;
    cs_we       = 1'b0;
    cs_waddr    = clr_idx_q;
    cs_wdata    = 8'd0;
    op_pop_o    = 1'b0;
    out_push    = 1'b0;
    out_data    = '0;
    back_stat_o = '{init_done: 1'b1, commit_done: 1'b0};

    case (state_q)
      B_CLEAR: begin
        back_stat_o.init_done = 1'b0;
        cs_we     = 1'b1;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_ADDR) state_d = B_IDLE;
      end
      B_IDLE: begin
        // Only one request in flight, so a free result slot now is enough.
        if (op_valid_i && out_cnt_q != 2'd2) begin
          op_pop_o = 1'b1;
          case (op_i.kind)
            OP_READ: begin
              in_range_d = ({1'b0, op_i.addr} < DEPTH_LIM);
              state_d    = B_READ;
            end
            OP_COMMIT: begin
              op_addr_d   = op_i.addr;
              op_cnt_d    = op_i.count;
              op_status_d = op_i.status;
              copy_idx_d  = '0;
              if (op_i.count == 8'd0) begin
                out_push               = 1'b1;
                out_data.status        = op_i.status;
                back_stat_o.commit_done = 1'b1;
              end else begin
                state_d = B_COPY_RD;
              end
            end
            default: begin
              out_push        = 1'b1;
              out_data.status = op_i.status;
            end
          endcase
        end
      end
      B_READ: begin
        out_push           = 1'b1;
        out_data.status    = ST_RUN;
        out_data.read_data = in_range_q ? cs_rdata_q : 8'd0;
        state_d            = B_IDLE;
      end
      B_COPY_RD: begin
        state_d = B_COPY_WR;
      end
      B_COPY_WR: begin
        // Bytes past the top of code memory are dropped, no wrap.
        cs_we      = (copy_addr < DEPTH_LIM);
        cs_waddr   = copy_addr[ADDR_W-1:0];
        cs_wdata   = buf_rdata_q;
        copy_idx_d = copy_idx_q + 1'b1;
        if (({1'b0, copy_idx_q} + 9'd1) == {1'b0, op_cnt_q}) begin
          out_push               = 1'b1;
          out_data.status        = op_status_q;
          back_stat_o.commit_done = 1'b1;
          state_d                = B_IDLE;
        end else begin
          state_d = B_COPY_RD;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) code_q[cs_waddr] <= cs_wdata;
    cs_rdata_q <= code_q[cs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) rec_buf_q[buf_wr_i.idx] <= buf_wr_i.data;
    buf_rdata_q <= rec_buf_q[copy_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (out_push) out_mem_q[out_wptr_q] <= out_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_idx_q   <= '0;
      op_addr_q   <= 16'd0;
      op_cnt_q    <= 8'd0;
      op_status_q <= ST_RUN;
      in_range_q  <= 1'b0;
      copy_idx_q  <= '0;
      out_wptr_q  <= 1'b0;
      out_rptr_q  <= 1'b0;
      out_cnt_q   <= 2'd0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      op_addr_q   <= op_addr_d;
      op_cnt_q    <= op_cnt_d;
      op_status_q <= op_status_d;
      in_range_q  <= in_range_d;
      copy_idx_q  <= copy_idx_d;
      if (out_push) out_wptr_q <= ~out_wptr_q;
      if (out_pop) out_rptr_q <= ~out_rptr_q;
      if (out_push && !out_pop) out_cnt_q <= out_cnt_q + 2'd1;
      else if (out_pop && !out_push) out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

endmodule
